[rtl/assert_macros.svh]
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check an implication on every rising clock edge, skipped while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/bs_pkg.sv]
// Shared types, field widths and parameter defaults of the bit store block.
`default_nettype none

package bs_pkg;

    localparam int NUM_WORDS_DEF = 131072;
    localparam int WORD_BITS_DEF = 8;

    localparam int OPCODE_W  = 2;
    localparam int CNT_W     = 20;
    localparam int IDX_W     = 20;
    localparam int LEFT_W    = 20;
    localparam int RIGHT_W   = 21;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_GET   = 2'd1,
        OP_SET   = 2'd2,
        OP_ANY   = 2'd3
    } op_t;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_ANY = 1'b1;

endpackage

`default_nettype wire

[rtl/bitset_get_set_range_any_core.sv]
// Bit store with clear-prefix, get, set and any-in-range operations.
// Get reads the word on accept and tests it in S_GET; set rewrites it in S_SET.
// Clear: zeroes words 0..min(clear_count/WORD_BITS + 1, NUM_WORDS - 1), one write per cycle.
// Any: an empty range is answered without a memory read, else one memory read a cycle.
// Reset: a clearing pass zeroes all NUM_WORDS words; s_tready stays low meanwhile.
// Word and bit position come from shifts, so WORD_BITS must be a power of two.
`default_nettype none

module bitset_get_set_range_any_core #(
    parameter int NUM_WORDS = bs_pkg::NUM_WORDS_DEF,
    parameter int WORD_BITS = bs_pkg::WORD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [19:0] clear_count, [39:20] bit_index, [40] new_value,
    // [60:41] range_left, [81:61] range_right, [87:82] zero
    input  wire logic [bs_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  wire logic [bs_pkg::OPCODE_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] answer_bit, [7:1] zero
    output logic      [bs_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] answer_kind
    output logic                                m_tuser
);

    localparam int AW = $clog2(NUM_WORDS);
    localparam int PW = $clog2(WORD_BITS);
    localparam int CW = (AW + 2 > 22) ? AW + 2 : 22;
    localparam logic [CW-1:0] NW_C    = CW'(NUM_WORDS);
    localparam logic [CW-1:0] LAST_C  = CW'(NUM_WORDS - 1);
    localparam logic [PW-1:0] TOP_POS = PW'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GET,
        S_SET,
        S_ANY,
        S_DONE
    } state_t;

    // input word fields
    bs_pkg::op_t                 in_op;
    logic [bs_pkg::CNT_W-1:0]    in_count;
    logic [bs_pkg::IDX_W-1:0]    in_index;
    logic                        in_value;
    logic [bs_pkg::LEFT_W-1:0]   in_left;
    logic [bs_pkg::RIGHT_W-1:0]  in_right;

    assign in_op    = bs_pkg::op_t'(s_tuser);
    assign in_count = s_tdata[19:0];
    assign in_index = s_tdata[39:20];
    assign in_value = s_tdata[40];
    assign in_left  = s_tdata[60:41];
    assign in_right = s_tdata[81:61];

    // decode
    logic [CW-1:0]               idx_word;
    logic                        idx_oor;
    logic [CW-1:0]               clr_word;
    logic [CW-1:0]               clr_last;
    logic [CW-1:0]               left_word;
    logic [bs_pkg::RIGHT_W-1:0]  right_m1;
    logic [CW-1:0]               right_word;
    logic                        right_past;
    logic                        any_empty;
    logic [CW-1:0]               any_last;
    logic [PW-1:0]               any_hi;

    always_comb begin
        idx_word   = CW'(in_index >> PW);
        idx_oor    = idx_word >= NW_C;
        clr_word   = CW'(in_count >> PW) + CW'(1);
        clr_last   = (clr_word >= LAST_C) ? LAST_C : clr_word;
        left_word  = CW'(in_left >> PW);
        right_m1   = in_right - bs_pkg::RIGHT_W'(1);
        right_word = CW'(right_m1 >> PW);
        right_past = right_word >= NW_C;
        any_empty  = ({1'b0, in_left} >= in_right) || (left_word >= NW_C);
        any_last   = right_past ? LAST_C : right_word;
        any_hi     = right_past ? TOP_POS : right_m1[PW-1:0];
    end

    // registers
    state_t          state_reg, state_next;
    logic [CW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   last_reg, last_next;
    logic            chk_valid_reg, chk_valid_next;
    logic            chk_first_reg, chk_first_next;
    logic            chk_last_reg, chk_last_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            m_bit_reg;
    logic            m_kind_reg;
    logic            res_bit_reg;
    logic            res_kind_reg;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   hi_reg;
    logic            val_reg;
    logic            oor_reg;

    // control
    logic                  load_item;
    logic                  load_out;
    logic                  store_res;
    logic                  fin;
    logic                  fin_bit;
    logic                  fin_kind;
    logic                  out_bit;
    logic                  out_kind;
    logic                  ram_en;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [PW-1:0]         unit_lo;
    logic [PW-1:0]         unit_hi;
    logic                  unit_hit;
    logic [WORD_BITS-1:0]  unit_word;

    assign s_tready = (state_reg == S_IDLE);

    assign unit_lo = (state_reg == S_ANY) ? (chk_first_reg ? pos_reg : '0) : pos_reg;
    assign unit_hi = (state_reg == S_ANY) ? (chk_last_reg ? hi_reg : TOP_POS) : pos_reg;

    bs_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .word     (ram_rdata),
        .lo_pos   (unit_lo),
        .hi_pos   (unit_hi),
        .set_pos  (pos_reg),
        .set_val  (val_reg),
        .hit      (unit_hit),
        .new_word (unit_word)
    );

    bs_ram #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        chk_valid_next = 1'b0;
        chk_first_next = chk_first_reg;
        chk_last_next  = chk_last_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        load_item      = 1'b0;
        load_out       = 1'b0;
        store_res      = 1'b0;
        fin            = 1'b0;
        fin_bit        = 1'b0;
        fin_kind       = bs_pkg::KIND_GET;
        out_bit        = res_bit_reg;
        out_kind       = res_kind_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = cur_reg[AW-1:0];
        ram_wdata      = '0;

        case (state_reg)
            S_CLEAR: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                if (cur_reg == last_reg) begin
                    state_next = S_IDLE;
                end else begin
                    cur_next = cur_reg + CW'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    load_item = 1'b1;
                    case (in_op)
                        bs_pkg::OP_CLEAR: begin
                            cur_next   = '0;
                            last_next  = clr_last;
                            state_next = S_CLEAR;
                        end
                        bs_pkg::OP_GET: begin
                            ram_en     = !idx_oor;
                            ram_addr   = idx_word[AW-1:0];
                            cur_next   = idx_word;
                            state_next = S_GET;
                        end
                        bs_pkg::OP_SET: begin
                            ram_en     = !idx_oor;
                            ram_addr   = idx_word[AW-1:0];
                            cur_next   = idx_word;
                            state_next = S_SET;
                        end
                        default: begin
                            if (any_empty) begin
                                fin      = 1'b1;
                                fin_bit  = 1'b0;
                                fin_kind = bs_pkg::KIND_ANY;
                            end else begin
                                cur_next   = left_word;
                                last_next  = any_last;
                                state_next = S_ANY;
                            end
                        end
                    endcase
                end
            end
            S_GET: begin
                fin      = 1'b1;
                fin_bit  = !oor_reg && unit_hit;
                fin_kind = bs_pkg::KIND_GET;
            end
            S_SET: begin
                ram_en     = !oor_reg;
                ram_we     = !oor_reg;
                ram_wdata  = unit_word;
                state_next = S_IDLE;
            end
            S_ANY: begin
                if (chk_valid_reg && unit_hit) begin
                    fin      = 1'b1;
                    fin_bit  = 1'b1;
                    fin_kind = bs_pkg::KIND_ANY;
                end else if (chk_valid_reg && chk_last_reg) begin
                    fin      = 1'b1;
                    fin_bit  = 1'b0;
                    fin_kind = bs_pkg::KIND_ANY;
                end else begin
                    // issue the next word read; its test happens in the next cycle
                    ram_en         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_first_next = !chk_valid_reg;
                    chk_last_next  = (cur_reg == last_reg);
                    cur_next       = cur_reg + CW'(1);
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            if (!m_tvalid_reg || m_tready) begin
                load_out   = 1'b1;
                out_bit    = fin_bit;
                out_kind   = fin_kind;
                state_next = S_IDLE;
            end else begin
                // hold the answer until the output register frees up
                store_res  = 1'b1;
                state_next = S_DONE;
            end
        end

        if (load_out) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            last_reg      <= LAST_C;
            chk_valid_reg <= 1'b0;
            chk_first_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            chk_valid_reg <= chk_valid_next;
            chk_first_reg <= chk_first_next;
            chk_last_reg  <= chk_last_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_item) begin
            pos_reg <= (in_op == bs_pkg::OP_ANY) ? in_left[PW-1:0] : in_index[PW-1:0];
            hi_reg  <= any_hi;
            val_reg <= in_value;
            oor_reg <= idx_oor;
        end
        if (store_res) begin
            res_bit_reg  <= fin_bit;
            res_kind_reg <= fin_kind;
        end
        if (load_out) begin
            m_bit_reg  <= out_bit;
            m_kind_reg <= out_kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(bs_pkg::M_TDATA_W - 1){1'b0}}, m_bit_reg};
    assign m_tuser  = m_kind_reg;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_any_read_in_span, aclk, aresetn, (state_reg == S_ANY) && ram_en, cur_reg <= last_reg, "range scan read past its last word")
    `ASSERT_IMPL(a_check_only_in_scan, aclk, aresetn, chk_valid_reg, state_reg == S_ANY, "word check pending outside a range scan")
    `ASSERT_IMPL(a_answer_source, aclk, aresetn, $rose(m_tvalid_reg), ($past(state_reg) != S_CLEAR) && ($past(state_reg) != S_SET), "answer raised by an operation without one")
    `ASSERT_CLK(a_no_accept_in_clear, aclk, aresetn, !((state_reg == S_CLEAR) && load_item), "word accepted during a clearing pass")

endmodule

`default_nettype wire

[rtl/bs_ram.sv]
// Single-port word memory with registered read data.
`default_nettype none

module bs_ram #(
    parameter int NUM_WORDS = bs_pkg::NUM_WORDS_DEF,
    parameter int WORD_BITS = bs_pkg::WORD_BITS_DEF,
    localparam int AW = $clog2(NUM_WORDS)
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        addr,
    input  wire logic [WORD_BITS-1:0] wdata,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bs_word_unit.sv]
// Shared word unit: tests a bit span of a word and rewrites a single bit.
`default_nettype none

module bs_word_unit #(
    parameter int WORD_BITS = bs_pkg::WORD_BITS_DEF,
    localparam int PW = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [PW-1:0]        lo_pos,
    input  wire logic [PW-1:0]        hi_pos,
    input  wire logic [PW-1:0]        set_pos,
    input  wire logic                 set_val,
    output logic                      hit,
    output logic      [WORD_BITS-1:0] new_word
);

    logic [WORD_BITS-1:0] mask;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (PW'(i) >= lo_pos) && (PW'(i) <= hi_pos);
        end
        hit = |(word & mask);
        new_word = word;
        new_word[set_pos] = set_val;
    end

endmodule

`default_nettype wire

[test/tb_bitset_get_set_range_any_core.sv]
// Self-checking testbench for the bit store core: clear, get, set and any-in-range.
module tb_bitset_get_set_range_any_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bs_pkg::*;

    localparam int unsigned STORE_WORDS = NUM_WORDS_DEF;
    localparam int unsigned WORD_BITS   = WORD_BITS_DEF;
    localparam int unsigned STORE_BITS  = STORE_WORDS * WORD_BITS;
    localparam int unsigned MAX_POS     = STORE_BITS - 1;
    localparam int unsigned RANDOM_OPS  = 1900;
    localparam int unsigned STALL_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 3000;
    localparam int unsigned HOLD_CYCLES = 2500;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct {
        op_t         opcode;
        bit [19:0]   clear_count;
        bit [19:0]   bit_index;
        bit          new_value;
        bit [19:0]   range_left;
        bit [20:0]   range_right;
    } bs_op_t;

    typedef struct packed {
        logic answer_bit;
        logic answer_kind;
    } answer_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    bs_op_t      pending_ops[$];
    answer_t     expected_answers[$];
    bit [7:0]    mirror_words [STORE_WORDS];

    logic        in_fire = 1'b0;
    int unsigned error_count = 0;
    int unsigned answers_seen = 0;
    int unsigned stall_cycles = 0;

    bitset_get_set_range_any_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // True if any mirrored bit in [left, right) is set, right clamped to the store.
    function automatic logic range_has_one(input int unsigned left, input int unsigned right);
        int unsigned first_w;
        int unsigned last_w;
        int unsigned lo;
        int unsigned hi;
        logic [7:0]  mask;
        if (right > STORE_BITS) right = STORE_BITS;
        if (left >= right) return 1'b0;
        first_w = left / WORD_BITS;
        last_w  = (right - 1) / WORD_BITS;
        for (int unsigned w = first_w; w <= last_w; w++) begin
            lo = (w == first_w) ? left % WORD_BITS : 0;
            hi = (w == last_w) ? (right - 1) % WORD_BITS + 1 : WORD_BITS;
            mask = 8'((9'd1 << hi) - 9'd1) & ~8'((9'd1 << lo) - 9'd1);
            if ((mirror_words[w] & mask) != 8'd0) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Update the mirrored store and queue the answer this word produces.
    function automatic void apply_to_mirror(input bs_op_t op);
        int unsigned span;
        int unsigned w;
        int unsigned p;
        case (op.opcode)
            OP_CLEAR: begin
                span = op.clear_count / WORD_BITS + 2;
                if (span > STORE_WORDS) span = STORE_WORDS;
                for (int unsigned i = 0; i < span; i++) mirror_words[i] = 8'd0;
            end
            OP_GET: begin
                w = op.bit_index / WORD_BITS;
                p = op.bit_index % WORD_BITS;
                expected_answers.push_back('{answer_bit: mirror_words[w][p],
                                             answer_kind: KIND_GET});
            end
            OP_SET: begin
                w = op.bit_index / WORD_BITS;
                p = op.bit_index % WORD_BITS;
                mirror_words[w][p] = op.new_value;
            end
            default: begin
                expected_answers.push_back('{answer_bit: range_has_one(op.range_left,
                                                                        op.range_right),
                                             answer_kind: KIND_ANY});
            end
        endcase
    endfunction

    // Bits of the store that most operations land on, so that gets and ranges see data.
    function automatic int unsigned pick_position();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 2047);
        if (r < 65) return $urandom_range(STORE_BITS - 2048, MAX_POS);
        return $urandom_range(0, MAX_POS);
    endfunction

    // Push one word; unused fields get random content. a and b depend on the operation.
    task automatic queue_op(input op_t opcode, input int unsigned a, input int unsigned b);
        bs_op_t op;
        op.opcode      = opcode;
        op.clear_count = 20'($urandom_range(0, MAX_POS));
        op.bit_index   = 20'($urandom_range(0, MAX_POS));
        op.new_value   = 1'($urandom_range(0, 1));
        op.range_left  = 20'($urandom_range(0, MAX_POS));
        op.range_right = 21'($urandom_range(0, STORE_BITS));
        case (opcode)
            OP_CLEAR: op.clear_count = 20'(a);
            OP_GET:   op.bit_index = 20'(a);
            OP_SET: begin
                op.bit_index = 20'(a);
                op.new_value = 1'(b);
            end
            default: begin
                op.range_left  = 20'(a);
                op.range_right = 21'(b);
            end
        endcase
        pending_ops.push_back(op);
    endtask

    task automatic queue_random_op();
        int unsigned r;
        int unsigned left;
        int unsigned right;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            queue_op(OP_CLEAR,
                     ($urandom_range(0, 6) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 2047), 0);
        end else if (r < 38) begin
            queue_op(OP_GET, pick_position(), 0);
        end else if (r < 72) begin
            queue_op(OP_SET, pick_position(), $urandom_range(0, 1));
        end else begin
            left = pick_position();
            r = $urandom_range(0, 99);
            if (r < 10)      right = $urandom_range(0, left);
            else if (r < 88) right = left + $urandom_range(1, 96);
            else             right = left + $urandom_range(1, 16384);
            if (right > STORE_BITS) right = STORE_BITS;
            queue_op(OP_ANY, left, right);
        end
    endtask

    // Driver: bursts of words with random gaps, a word held until taken.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // hold the offered word
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
        end else if (pending_ops.size() == 0) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_ops[0].opcode;
            s_tdata  <= {6'd0, pending_ops[0].range_right, pending_ops[0].range_left,
                         pending_ops[0].new_value, pending_ops[0].bit_index,
                         pending_ops[0].clear_count};
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    end

    // Receiver: ready pattern is redrawn at random periodically; one long hold-off mid-run.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_left == 0 && !hold_done && answers_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_cycle[0];
            endcase
        end
    end

    // Monitor: check each answer against the oldest expectation, then predict new input.
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (m_tvalid && m_tready) begin
            got = '{answer_bit: m_tdata[0], answer_kind: m_tuser};
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected answer: bit %0b kind %0b", got.answer_bit,
                             got.answer_kind);
            end else begin
                want = expected_answers.pop_front();
                if (got != want) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("answer mismatch: expected bit %0b kind %0b, got bit %0b kind %0b",
                                 want.answer_bit, want.answer_kind,
                                 got.answer_bit, got.answer_kind);
                end
            end
        end
        if (s_tvalid && s_tready) begin
            apply_to_mirror(pending_ops[0]);
            void'(pending_ops.pop_front());
        end
        in_fire <= s_tvalid && s_tready;
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        queue_op(OP_GET, 0, 0);
        queue_op(OP_SET, 0, 1);
        queue_op(OP_GET, 0, 0);
        queue_op(OP_SET, MAX_POS, 1);
        queue_op(OP_GET, MAX_POS, 0);
        queue_op(OP_ANY, MAX_POS, STORE_BITS);
        queue_op(OP_ANY, 5, 5);
        queue_op(OP_ANY, 10, 3);
        queue_op(OP_ANY, MAX_POS, MAX_POS);
        queue_op(OP_ANY, 0, 1);
        queue_op(OP_ANY, 1, 9);
        queue_op(OP_SET, 13, 1);
        queue_op(OP_ANY, 8, 13);
        queue_op(OP_ANY, 8, 14);
        queue_op(OP_SET, 13, 0);
        queue_op(OP_GET, 13, 0);
        queue_op(OP_CLEAR, 0, 0);
        queue_op(OP_GET, 0, 0);
        // word 2 survives a clear of count 7 but not of count 8
        queue_op(OP_SET, 23, 1);
        queue_op(OP_CLEAR, 7, 0);
        queue_op(OP_GET, 23, 0);
        queue_op(OP_CLEAR, 8, 0);
        queue_op(OP_GET, 23, 0);
        // clear past the end, then a full-store range that only finds the last bit
        queue_op(OP_CLEAR, MAX_POS, 0);
        queue_op(OP_SET, MAX_POS, 1);
        queue_op(OP_ANY, 0, STORE_BITS);
        for (int unsigned i = 0; i < RANDOM_OPS; i++) queue_random_op();
        queue_op(OP_GET, pick_position(), 0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_ops.size() != 0 || expected_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/bs_pkg.sv
rtl/bs_ram.sv
rtl/bs_word_unit.sv
rtl/bitset_get_set_range_any_core.sv
test/tb_bitset_get_set_range_any_core.sv
